// ===== hdl/flux_beat_detector_defines.svh =====
// assertion macros shared by the detector rtl
`ifndef FLUX_BEAT_DETECTOR_DEFINES_SVH
`define FLUX_BEAT_DETECTOR_DEFINES_SVH

// same-cycle implication, sampled on clk_i, quiet during reset
`define FBD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication failed");

// next-cycle implication, sampled on clk_i, quiet during reset
`define FBD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== hdl/fbd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package fbd_pkg;

  // configuration register indexes
  localparam logic [2:0] CfgMult   = 3'd0;
  localparam logic [2:0] CfgFloor  = 3'd1;
  localparam logic [2:0] CfgBase   = 3'd2;
  localparam logic [2:0] CfgScale  = 3'd3;
  localparam logic [2:0] CfgOffset = 3'd4;
  localparam logic [2:0] CfgTFloor = 3'd5;
  localparam logic [2:0] CfgDiv    = 3'd6;

  // register reset values
  localparam logic [31:0] RstMult   = 32'd98304;
  localparam logic [31:0] RstFloor  = 32'd655;
  localparam logic [31:0] RstBase   = 32'd131072;
  localparam logic [31:0] RstScale  = 32'd65536;
  localparam logic [31:0] RstOffset = 32'd0;
  localparam logic [31:0] RstTFloor = 32'd6554;
  localparam logic [31:0] RstDiv    = 32'd65536;

  // fixed-point constants
  localparam logic [20:0] SinceMax    = 21'd1048576;
  localparam logic [20:0] MinInterval = 21'd13107;
  localparam logic [16:0] LevelOne    = 17'd65536;
  localparam logic [16:0] LevelHalf   = 17'd32768;
  localparam logic [47:0] KeepQ16     = 48'd64225;
  localparam logic [47:0] TakeQ16     = 48'd1311;
  localparam logic [47:0] SixTenths   = 48'd39322;
  localparam logic [31:0] U32Max      = 32'hFFFF_FFFF;
  localparam logic [3:0]  TaylorTerms = 4'd12;

  // shift-add / restoring divide step counts
  localparam logic [6:0] MulSteps = 7'd48;
  localparam logic [6:0] DivSteps = 7'd64;

  typedef enum logic {
    ARITH_MUL = 1'b0,
    ARITH_DIV = 1'b1
  } arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_sts_t;

  // e^n in Q16.16, rounded
  function automatic logic [39:0] exp_int_q16(input logic [4:0] n);
    logic [39:0] v;
    case (n)
      5'd0:    v = 40'd65536;
      5'd1:    v = 40'd178145;
      5'd2:    v = 40'd484249;
      5'd3:    v = 40'd1316326;
      5'd4:    v = 40'd3578144;
      5'd5:    v = 40'd9726405;
      5'd6:    v = 40'd26439109;
      5'd7:    v = 40'd71868951;
      5'd8:    v = 40'd195360063;
      5'd9:    v = 40'd531043708;
      5'd10:   v = 40'd1443526462;
      5'd11:   v = 40'd3923911752;
      5'd12:   v = 40'd10666298010;
      5'd13:   v = 40'd28994004059;
      5'd14:   v = 40'd78813874367;
      5'd15:   v = 40'd214238322522;
      5'd16:   v = 40'd582360139072;
      default: v = 40'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/fbd_serial_arith.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fbd_serial_arith
  import fbd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire arith_req_t  req_i,
  input  wire logic [47:0] mul_a_i,
  input  wire logic [47:0] mul_b_i,
  input  wire logic [63:0] div_n_i,
  input  wire logic [63:0] div_d_i,
  output arith_sts_t       sts_o,
  output logic [95:0]      prod_o,
  output logic [63:0]      quot_o
);

  logic [63:0] hi_q, hi_d;
  logic [63:0] lo_q, lo_d;
  logic [63:0] opnd_q, opnd_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  arith_op_e   op_q, op_d;

  // one multiplier bit or one quotient bit per cycle
  always_comb begin
    logic [48:0] msum;
    logic [64:0] rem;
    logic        ge;
    hi_d   = hi_q;
    lo_d   = lo_q;
    opnd_d = opnd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    op_d   = op_q;
    done_d = 1'b0;
    msum   = {1'b0, hi_q[47:0]} + (lo_q[0] ? {1'b0, opnd_q[47:0]} : 49'd0);
    rem    = {hi_q, lo_q[63]};
    ge     = (rem >= {1'b0, opnd_q});
    if (busy_q) begin
      if (op_q == ARITH_MUL) begin
        hi_d = {16'd0, msum[48:1]};
        lo_d = {16'd0, msum[0], lo_q[47:1]};
      end else begin
        hi_d = ge ? 64'(rem - {1'b0, opnd_q}) : rem[63:0];
        lo_d = {lo_q[62:0], ge};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      op_d   = req_i.op;
      busy_d = 1'b1;
      hi_d   = 64'd0;
      if (req_i.op == ARITH_MUL) begin
        lo_d   = {16'd0, mul_b_i};
        opnd_d = {16'd0, mul_a_i};
        cnt_d  = MulSteps;
      end else begin
        lo_d   = div_n_i;
        opnd_d = div_d_i;
        cnt_d  = DivSteps;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 7'd0;
      op_q   <= ARITH_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    opnd_q <= opnd_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign prod_o     = {hi_q[47:0], lo_q[47:0]};
  assign quot_o     = lo_q;

endmodule
`default_nettype wire

// ===== hdl/flux_beat_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Spectral-flux beat detector. One request in (low-band flux, frame time) gives
// one request out (beat level, beat flag). All multiplies and divides run through
// one shared bit-serial unit. A frame without a beat needs four or six
// multiplies; a frame that fires a beat adds the exponential (twelve
// multiply/divide pairs and a multiply by the integer power), two multiplies
// for the adaptation value and its denominator, and the falloff division. The
// input stalls while a frame is in work; a finished result waits in the output
// register while the next request is taken.
`include "flux_beat_detector_defines.svh"
module flux_beat_detector
  import fbd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] low_band_flux_i,
  input  wire logic [15:0] frame_time_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [16:0]      beat_level_o,
  output logic             beat_now_o
);

  typedef enum logic [13:0] {
    ST_IDLE    = 14'b00000000000001,
    ST_THR_A   = 14'b00000000000010,
    ST_THR_B   = 14'b00000000000100,
    ST_CMP     = 14'b00000000001000,
    ST_EXP_MUL = 14'b00000000010000,
    ST_EXP_DIV = 14'b00000000100000,
    ST_EXP_INT = 14'b00000001000000,
    ST_ADAPT   = 14'b00000010000000,
    ST_DENOM   = 14'b00000100000000,
    ST_FALL    = 14'b00001000000000,
    ST_DECAY_A = 14'b00010000000000,
    ST_DECAY_B = 14'b00100000000000,
    ST_DECAY_C = 14'b01000000000000,
    ST_DONE    = 14'b10000000000000
  } state_e;

  state_e      state_q, state_d;
  logic        issued_q, issued_d;
  logic [31:0] mult_q, floor_q, base_q, scale_q, offs_q, tfloor_q, tdiv_q;
  logic [31:0] thr_q, thr_d;
  logic [20:0] since_q, since_d;
  logic [16:0] level_q, level_d;
  logic [31:0] fall_q, fall_d;
  logic        beat_q, beat_d;
  logic        out_valid_q, out_valid_d;
  logic [16:0] out_level_q, out_level_d;
  logic        out_beat_q, out_beat_d;
  logic [31:0] flux_q, flux_d;
  logic [15:0] dt_q, dt_d;
  logic [63:0] acc_q, acc_d;
  logic [32:0] tmp_q, tmp_d;
  logic [32:0] term_q, term_d;
  logic [34:0] sum_q, sum_d;
  logic [3:0]  k_q, k_d;
  logic [40:0] e_q, e_d;
  logic [31:0] adapt_q, adapt_d;
  logic [31:0] decay_q, decay_d;

  arith_req_t  arith_req;
  arith_sts_t  arith_sts;
  logic        arith_start;
  logic [47:0] mul_a, mul_b;
  logic [63:0] div_n, div_d;
  logic [95:0] prod;
  logic [63:0] quot;

  fbd_serial_arith u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (arith_req),
    .mul_a_i (mul_a),
    .mul_b_i (mul_b),
    .div_n_i (div_n),
    .div_d_i (div_d),
    .sts_o   (arith_sts),
    .prod_o  (prod),
    .quot_o  (quot)
  );

  // operand selection for the shared unit
  always_comb begin
    logic [35:0] sum_r;
    sum_r  = {1'b0, sum_q} + 36'd32768;
    arith_req.start = arith_start;
    arith_req.op = ARITH_MUL;
    mul_a  = 48'd0;
    mul_b  = 48'd0;
    div_n  = 64'd0;
    div_d  = 64'd0;
    case (state_q)
      ST_THR_A: begin
        mul_a = {16'd0, thr_q};
        mul_b = KeepQ16;
      end
      ST_THR_B: begin
        mul_a = {16'd0, flux_q};
        mul_b = TakeQ16;
      end
      ST_CMP: begin
        mul_a = {16'd0, thr_q};
        mul_b = {16'd0, mult_q};
      end
      ST_EXP_MUL: begin
        mul_a = {15'd0, term_q};
        mul_b = {32'd0, since_q[15:0]};
      end
      ST_EXP_DIV: begin
        arith_req.op = ARITH_DIV;
        div_n = {31'd0, tmp_q};
        div_d = {60'd0, k_q};
      end
      ST_EXP_INT: begin
        mul_a = {8'd0, exp_int_q16(since_q[20:16])};
        mul_b = {28'd0, sum_r[35:16]};
      end
      ST_ADAPT: begin
        mul_a = {16'd0, scale_q};
        mul_b = {7'd0, e_q};
      end
      ST_DENOM: begin
        mul_a = {16'd0, adapt_q};
        mul_b = {16'd0, tdiv_q};
      end
      ST_FALL: begin
        arith_req.op = ARITH_DIV;
        div_n = {1'b0, base_q, 31'd0};
        div_d = acc_q;
      end
      ST_DECAY_A: begin
        mul_a = {16'd0, fall_q};
        mul_b = {32'd0, dt_q};
      end
      ST_DECAY_B: begin
        mul_a = {16'd0, decay_q};
        mul_b = SixTenths;
      end
      ST_DECAY_C: begin
        mul_a = acc_q[47:0];
        mul_b = {31'd0, level_q};
      end
      default: begin
        mul_a = 48'd0;
      end
    endcase
  end

  // frame sequencer
  always_comb begin
    logic [21:0] since_sum;
    logic [63:0] thr_sum;
    logic [63:0] e_r;
    logic [48:0] adapt_sum;
    logic [31:0] adapt_v;
    logic [31:0] decay_v;
    logic [32:0] sub_v;
    logic        compute;
    since_sum   = {1'b0, since_q} + {6'd0, frame_time_i};
    thr_sum     = acc_q + prod[63:0] + 64'd32768;
    e_r         = prod[63:0] + 64'd32768;
    adapt_sum   = {1'b0, prod[63:16]} + {17'd0, offs_q};
    decay_v     = prod[47:16];
    sub_v       = prod[64:32];
    adapt_v     = U32Max;
    state_d     = state_q;
    issued_d    = issued_q;
    thr_d       = thr_q;
    since_d     = since_q;
    level_d     = level_q;
    fall_d      = fall_q;
    beat_d      = beat_q;
    flux_d      = flux_q;
    dt_d        = dt_q;
    acc_d       = acc_q;
    tmp_d       = tmp_q;
    term_d      = term_q;
    sum_d       = sum_q;
    k_d         = k_q;
    e_d         = e_q;
    adapt_d     = adapt_q;
    decay_d     = decay_q;
    out_valid_d = out_valid_q;
    out_level_d = out_level_q;
    out_beat_d  = out_beat_q;
    arith_start = 1'b0;
    compute = (state_q != ST_IDLE) && (state_q != ST_DONE);

    // output register drains independently
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // launch the pending operation once per state
    if (compute && !issued_q) begin
      if ((state_q == ST_FALL) && (acc_q == 64'd0)) begin
        fall_d  = U32Max;
        since_d = 21'd0;
        state_d = ST_DECAY_A;
      end else begin
        arith_start = 1'b1;
        issued_d    = 1'b1;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          flux_d  = low_band_flux_i;
          dt_d    = frame_time_i;
          since_d = (since_sum > {1'b0, SinceMax}) ? SinceMax : since_sum[20:0];
          state_d = ST_THR_A;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_level_d = level_q;
          out_beat_d  = beat_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        if (issued_q && arith_sts.done) begin
          issued_d = 1'b0;
          case (state_q)
            ST_THR_A: begin
              acc_d   = prod[63:0];
              state_d = ST_THR_B;
            end
            ST_THR_B: begin
              thr_d   = thr_sum[47:16];
              state_d = ST_CMP;
            end
            ST_CMP: begin
              if (({16'd0, flux_q, 16'd0} > prod[63:0]) && (flux_q > floor_q)
                  && (since_q > MinInterval)) begin
                beat_d  = 1'b1;
                level_d = LevelOne;
                term_d  = 33'h1_0000_0000;
                sum_d   = 35'h1_0000_0000;
                k_d     = 4'd1;
                state_d = ST_EXP_MUL;
              end else begin
                beat_d  = 1'b0;
                state_d = ST_DECAY_A;
              end
            end
            ST_EXP_MUL: begin
              tmp_d   = prod[48:16];
              state_d = ST_EXP_DIV;
            end
            ST_EXP_DIV: begin
              term_d = quot[32:0];
              sum_d  = sum_q + {2'd0, quot[32:0]};
              if (k_q == TaylorTerms) begin
                state_d = ST_EXP_INT;
              end else begin
                k_d     = k_q + 4'd1;
                state_d = ST_EXP_MUL;
              end
            end
            ST_EXP_INT: begin
              e_d     = e_r[56:16];
              state_d = ST_ADAPT;
            end
            ST_ADAPT: begin
              if (prod[95:64] != 32'd0) begin
                adapt_v = U32Max;
              end else if (adapt_sum[48:32] != 17'd0) begin
                adapt_v = U32Max;
              end else begin
                adapt_v = adapt_sum[31:0];
              end
              adapt_d = (adapt_v < tfloor_q) ? tfloor_q : adapt_v;
              state_d = ST_DENOM;
            end
            ST_DENOM: begin
              acc_d   = prod[63:0];
              state_d = ST_FALL;
            end
            ST_FALL: begin
              fall_d  = (quot[63:32] != 32'd0) ? U32Max : quot[31:0];
              since_d = 21'd0;
              state_d = ST_DECAY_A;
            end
            ST_DECAY_A: begin
              decay_d = decay_v;
              if (level_q > LevelHalf) begin
                level_d = (decay_v < {15'd0, level_q}) ? (level_q - decay_v[16:0]) : 17'd0;
                state_d = ST_DONE;
              end else begin
                state_d = ST_DECAY_B;
              end
            end
            ST_DECAY_B: begin
              acc_d   = prod[63:0];
              state_d = ST_DECAY_C;
            end
            ST_DECAY_C: begin
              level_d = (sub_v < {16'd0, level_q}) ? (level_q - sub_v[16:0]) : 17'd0;
              state_d = ST_DONE;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q   <= RstMult;
      floor_q  <= RstFloor;
      base_q   <= RstBase;
      scale_q  <= RstScale;
      offs_q   <= RstOffset;
      tfloor_q <= RstTFloor;
      tdiv_q   <= RstDiv;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMult:   mult_q   <= cfg_data_i;
        CfgFloor:  floor_q  <= cfg_data_i;
        CfgBase:   base_q   <= cfg_data_i;
        CfgScale:  scale_q  <= cfg_data_i;
        CfgOffset: offs_q   <= cfg_data_i;
        CfgTFloor: tfloor_q <= cfg_data_i;
        CfgDiv:    tdiv_q   <= cfg_data_i;
        default: begin
          mult_q <= mult_q;
        end
      endcase
    end
  end

  // control and detector state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      thr_q       <= 32'd0;
      since_q     <= 21'd0;
      level_q     <= 17'd0;
      fall_q      <= RstBase;
      beat_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      thr_q       <= thr_d;
      since_q     <= since_d;
      level_q     <= level_d;
      fall_q      <= fall_d;
      beat_q      <= beat_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    flux_q      <= flux_d;
    dt_q        <= dt_d;
    acc_q       <= acc_d;
    tmp_q       <= tmp_d;
    term_q      <= term_d;
    sum_q       <= sum_d;
    k_q         <= k_d;
    e_q         <= e_d;
    adapt_q     <= adapt_d;
    decay_q     <= decay_d;
    out_level_q <= out_level_d;
    out_beat_q  <= out_beat_d;
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign beat_level_o = out_level_q;
  assign beat_now_o   = out_beat_q;

  // checks
  `FBD_ASSERT_IMP(a_start_idle_unit, arith_req.start, !arith_sts.busy)
  `FBD_ASSERT_IMP(a_done_awaited, arith_sts.done, issued_q)
  `FBD_ASSERT_NXT(a_accept_starts, in_valid_i && !in_stall_o, state_q == ST_THR_A)

endmodule
`default_nettype wire
